// File: hdl/bfea_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bfea_pkg;

  localparam int unsigned MaxExtentsDef = 16;
  localparam int unsigned PosBitsDef    = 24;
  localparam int unsigned PosW          = 24;
  localparam int unsigned LenW          = 25;
  localparam int unsigned AlignW        = 17;
  localparam int unsigned StampW        = 32;

  localparam logic [1:0] OpAlloc   = 2'd0;
  localparam logic [1:0] OpAligned = 2'd1;
  localparam logic [1:0] OpFree    = 2'd2;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StNoSpace  = 3'd1;
  localparam logic [2:0] StDupStart = 3'd2;
  localparam logic [2:0] StOvlPrev  = 3'd3;
  localparam logic [2:0] StOvlNext  = 3'd4;
  localparam logic [2:0] StFull     = 3'd5;

  localparam logic RegPoolStart = 1'b0;
  localparam logic RegPoolSize  = 1'b1;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_FIT, S_FIT_DONE, S_FSCAN, S_FDONE, S_TALLY, S_DONE
  } state_e;

  typedef struct packed {
    logic init;      // rebuild pool
    logic latch;     // capture request
    logic scan_fit;  // step fit scan
    logic fit_apply; // apply alloc result
    logic scan_free; // step free scan
    logic free_apply;
    logic scan_tally;
    logic tally_clr;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic free_req;  // request goes to free path
    logic fit_ok;    // no free phase pending
  } sts_t;

endpackage
`default_nettype wire

// File: hdl/best_fit_extent_allocator.sv
// Channel  | Handshake              | Signals
// request  | start, busy            | op_i position_i length_i alignment_i
// result   | done_o (1-cycle strobe)| status_o result_position_o free_total_o
//          |                        | fragment_count_o
// config   | cfg_valid_i, cfg_ready_o | cfg_index_i cfg_data_i
// Each phase scans the extent table one entry per cycle through the shared
// table index. Allocate runs the fit scan, free the free scan, an aligned
// allocate with alignment above 1 that finds a fit runs both (the free scan
// returns its leading gap), an unused op neither; every op then runs the tally scan.
// After reset or a config write the table is rebuilt in the init state.
// Results cannot be stalled; done_o pulses once per item.
`timescale 1ns / 1ps
`default_nettype none
module best_fit_extent_allocator #(
  parameter int unsigned MAX_EXTENTS = bfea_pkg::MaxExtentsDef
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         start,
  output logic                        busy,
  input  wire  [1:0]                  op_i,
  input  wire  [bfea_pkg::PosW-1:0]   position_i,
  input  wire  [bfea_pkg::LenW-1:0]   length_i,
  input  wire  [bfea_pkg::AlignW-1:0] alignment_i,
  output logic                        done_o,
  output logic [2:0]                  status_o,
  output logic [bfea_pkg::PosW-1:0]   result_position_o,
  output logic [bfea_pkg::LenW-1:0]   free_total_o,
  output logic [4:0]                  fragment_count_o,
  input  wire                         cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire  [0:0]                  cfg_index_i,
  input  wire  [bfea_pkg::LenW-1:0]   cfg_data_i
);
  import bfea_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [PosW-1:0] pool_start_q;
  logic [LenW-1:0] pool_size_q;
  logic cfg_wr;

  // a request offered in the same cycle wins over a register write
  assign cfg_ready_o = !busy && !start;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_start_q <= '0;
      pool_size_q  <= LenW'(4096);
    end else if (cfg_wr) begin
      if (cfg_index_i == RegPoolStart) pool_start_q <= cfg_data_i[PosW-1:0];
      else                             pool_size_q  <= cfg_data_i;
    end
  end

  bfea_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .cfg_wr_i(cfg_wr),
    .sts_i(sts), .busy_o(busy), .cmd_o(cmd)
  );

  bfea_dp #(.MAX_EXTENTS(MAX_EXTENTS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .pool_start_i(pool_start_q), .pool_size_i(pool_size_q),
    .op_i, .position_i, .length_i, .alignment_i,
    .done_o, .status_o, .result_position_o, .free_total_o, .fragment_count_o
  );
endmodule
`default_nettype wire

// File: hdl/bfea_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module bfea_ctrl (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           start_i,
  input  wire           cfg_wr_i,
  input  bfea_pkg::sts_t sts_i,
  output logic          busy_o,
  output bfea_pkg::cmd_t cmd_o
);
  import bfea_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      S_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = S_IDLE;
      end
      S_IDLE: begin
        busy_o = 1'b0;
        if (cfg_wr_i) begin
          state_d = S_INIT;
        end else if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_FIT;
        end
      end
      S_FIT: begin
        if (sts_i.free_req) begin
          state_d = S_FSCAN;
        end else begin
          cmd_o.scan_fit = 1'b1;
          if (sts_i.scan_last) state_d = S_FIT_DONE;
        end
      end
      S_FIT_DONE: begin
        cmd_o.fit_apply = 1'b1;
        state_d         = S_FSCAN;
      end
      S_FSCAN: begin
        if (sts_i.fit_ok) begin
          cmd_o.tally_clr = 1'b1;
          state_d         = S_TALLY;
        end else begin
          cmd_o.scan_free = 1'b1;
          if (sts_i.scan_last) state_d = S_FDONE;
        end
      end
      S_FDONE: begin
        cmd_o.free_apply = 1'b1;
        cmd_o.tally_clr  = 1'b1;
        state_d          = S_TALLY;
      end
      S_TALLY: begin
        cmd_o.scan_tally = 1'b1;
        if (sts_i.scan_last) state_d = S_DONE;
      end
      S_DONE: begin
        cmd_o.emit = 1'b1;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: hdl/bfea_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module bfea_dp #(
  parameter int unsigned MAX_EXTENTS = bfea_pkg::MaxExtentsDef
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  bfea_pkg::cmd_t             cmd_i,
  output bfea_pkg::sts_t             sts_o,
  input  wire  [bfea_pkg::PosW-1:0]  pool_start_i,
  input  wire  [bfea_pkg::LenW-1:0]  pool_size_i,
  input  wire  [1:0]                 op_i,
  input  wire  [bfea_pkg::PosW-1:0]  position_i,
  input  wire  [bfea_pkg::LenW-1:0]  length_i,
  input  wire  [bfea_pkg::AlignW-1:0] alignment_i,
  output logic                       done_o,
  output logic [2:0]                 status_o,
  output logic [bfea_pkg::PosW-1:0]  result_position_o,
  output logic [bfea_pkg::LenW-1:0]  free_total_o,
  output logic [4:0]                 fragment_count_o
);
  import bfea_pkg::*;

  localparam int unsigned POS_BITS = PosBitsDef;
  localparam int unsigned IdxW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int unsigned CntW = $clog2(MAX_EXTENTS + 1);
  localparam int unsigned AW   = POS_BITS + 2; // arithmetic width, holds space size
  localparam logic [AW-1:0] Space = AW'(1) << POS_BITS;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_EXTENTS - 1);

  // extent table: registers read through the scan index and the best-fit index, written at several places
  logic [POS_BITS-1:0] ext_s_q [MAX_EXTENTS];
  logic [AW-1:0]       ext_l_q [MAX_EXTENTS];
  logic [MAX_EXTENTS-1:0] used_q;
  logic [StampW-1:0]   stamp_q [MAX_EXTENTS];
  logic [StampW-1:0]   ctr_q;

  logic [IdxW-1:0] idx_q;
  logic [1:0]      op_q;
  logic [AW-1:0]   len_q, amask_q;
  logic            aligned_q;

  // fit scan
  logic            best_v_q;
  logic [IdxW-1:0] best_q;
  logic [AW-1:0]   best_l_q;
  logic [StampW-1:0] best_st_q;

  // free phase inputs
  logic            fr_q;      // a free phase is pending
  logic [AW-1:0]   fpos_q, flen_q;
  logic            fitok_q;
  logic [2:0]      st_q;
  logic [POS_BITS-1:0] rpos_q;

  // free scan
  logic            dup_q, pv_q, nv_q, sv_q;
  logic [IdxW-1:0] pi_q, ni_q, si_q;
  logic [AW-1:0]   ps_q, pe_q, ns_q, nl_q;

  // undo of aligned allocate's tail update
  logic            undo_v_q, undo_used_q;
  logic [IdxW-1:0] undo_i_q;
  logic [POS_BITS-1:0] undo_s_q;
  logic [AW-1:0]   undo_l_q;
  logic [StampW-1:0] undo_st_q, undo_ctr_q;

  logic [AW-1:0]   sum_q;
  logic [CntW-1:0] cnt_q;

  logic [AW-1:0] cur_s, cur_l, need;
  assign cur_s = AW'(ext_s_q[idx_q]);
  assign cur_l = ext_l_q[idx_q];
  assign need  = len_q + amask_q;

  assign sts_o.scan_last = (idx_q == LastIdx);
  assign sts_o.free_req  = (op_q == OpFree) || (op_q == 2'd3);
  assign sts_o.fit_ok    = !fr_q;

  // free-phase decision
  logic [AW-1:0] fend;
  logic f_err4a, mprev, mnext;
  logic [2:0] fstat;
  assign fend    = fpos_q + flen_q;
  assign f_err4a = fend > Space;
  assign mprev   = pv_q && (pe_q == fpos_q);
  assign mnext   = nv_q && (ns_q == fend);
  always_comb begin
    fstat = StOk;
    if (flen_q == '0)                   fstat = StOk;
    else if (f_err4a)                   fstat = StOvlNext;
    else if (dup_q)                     fstat = StDupStart;
    else if (pv_q && pe_q > fpos_q)     fstat = StOvlPrev;
    else if (nv_q && fend > ns_q)       fstat = StOvlNext;
    else if (!mprev && !mnext && !sv_q) fstat = StFull;
  end

  // aligned start
  logic [AW-1:0] bs, r, rend, bend;
  assign bs   = AW'(ext_s_q[best_q]);
  assign bend = bs + best_l_q;
  assign r    = (bs + amask_q) & ~amask_q;
  assign rend = r + len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      ctr_q  <= StampW'(1);
      idx_q  <= '0;
      done_o <= 1'b0;
      op_q   <= OpAlloc;
      fr_q   <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (cmd_i.init) begin : init_blk
        logic [AW-1:0] s, l, room;
        s = AW'(pool_start_i[POS_BITS-1:0]);
        l = AW'(pool_size_i);
        room = Space - s;
        if (l > room) l = room;
        used_q     <= MAX_EXTENTS'(l != '0);
        ext_s_q[0] <= s[POS_BITS-1:0];
        ext_l_q[0] <= l;
        for (int i = 0; i < MAX_EXTENTS; i++) stamp_q[i] <= '0;
        ctr_q <= StampW'(1);
        sum_q <= l;
        cnt_q <= CntW'(l != '0);
      end
      if (cmd_i.latch) begin
        op_q      <= op_i;
        len_q     <= AW'(length_i);
        aligned_q <= (op_i == OpAligned) && (alignment_i > AlignW'(1));
        amask_q   <= ((op_i == OpAligned) && (alignment_i > AlignW'(1))) ?
                     AW'(alignment_i - AlignW'(1)) : '0;
        idx_q     <= '0;
        best_v_q  <= 1'b0;
        fr_q      <= (op_i == OpFree);
        fpos_q    <= AW'(position_i[POS_BITS-1:0]);
        flen_q    <= AW'(length_i);
        st_q      <= StOk;
        rpos_q    <= '0;
        undo_v_q  <= 1'b0;
        dup_q <= 1'b0; pv_q <= 1'b0; nv_q <= 1'b0; sv_q <= 1'b0;
      end
      if (cmd_i.scan_fit) begin
        if (used_q[idx_q] && cur_l >= need &&
            (!best_v_q || cur_l < best_l_q ||
             (cur_l == best_l_q && stamp_q[idx_q] > best_st_q))) begin
          best_v_q  <= 1'b1;
          best_q    <= idx_q;
          best_l_q  <= cur_l;
          best_st_q <= stamp_q[idx_q];
        end
        idx_q <= sts_o.scan_last ? '0 : idx_q + 1'b1;
      end
      if (cmd_i.fit_apply) begin
        if (!best_v_q) begin
          st_q <= StNoSpace;
        end else begin : ap
          logic [AW-1:0] ts, tl;
          ts = aligned_q ? rend : bs + len_q;
          tl = aligned_q ? bend - rend : best_l_q - len_q;
          undo_v_q    <= aligned_q;
          undo_i_q    <= best_q;
          undo_used_q <= 1'b1;
          undo_s_q    <= ext_s_q[best_q];
          undo_l_q    <= best_l_q;
          undo_st_q   <= stamp_q[best_q];
          undo_ctr_q  <= ctr_q;
          if (tl == '0) begin
            used_q[best_q] <= 1'b0;
          end else begin
            ext_s_q[best_q] <= ts[POS_BITS-1:0];
            ext_l_q[best_q] <= tl;
            stamp_q[best_q] <= ctr_q;
            ctr_q <= ctr_q + 1'b1;
          end
          rpos_q <= aligned_q ? r[POS_BITS-1:0] : ext_s_q[best_q];
          fr_q   <= aligned_q;
          fpos_q <= bs;
          flen_q <= r - bs;
        end
      end
      if (cmd_i.scan_free) begin
        if (!used_q[idx_q]) begin
          if (!sv_q) begin sv_q <= 1'b1; si_q <= idx_q; end
        end else if (cur_s == fpos_q) begin
          dup_q <= 1'b1;
        end else if (cur_s < fpos_q) begin
          if (!pv_q || cur_s > ps_q) begin
            pv_q <= 1'b1; pi_q <= idx_q; ps_q <= cur_s; pe_q <= cur_s + cur_l;
          end
        end else if (!nv_q || cur_s < ns_q) begin
          nv_q <= 1'b1; ni_q <= idx_q; ns_q <= cur_s; nl_q <= cur_l;
        end
        idx_q <= sts_o.scan_last ? '0 : idx_q + 1'b1;
      end
      if (cmd_i.free_apply) begin
        if (fstat != StOk) begin
          st_q   <= fstat;
          rpos_q <= '0;
          if (undo_v_q) begin
            used_q[undo_i_q]  <= undo_used_q;
            ext_s_q[undo_i_q] <= undo_s_q;
            ext_l_q[undo_i_q] <= undo_l_q;
            stamp_q[undo_i_q] <= undo_st_q;
            ctr_q             <= undo_ctr_q;
          end
        end else if (flen_q != '0) begin
          ctr_q <= ctr_q + 1'b1;
          if (mprev) begin
            ext_l_q[pi_q] <= pe_q + flen_q - ps_q + (mnext ? nl_q : '0);
            stamp_q[pi_q] <= ctr_q;
            if (mnext) used_q[ni_q] <= 1'b0;
          end else if (mnext) begin
            ext_s_q[ni_q] <= fpos_q[POS_BITS-1:0];
            ext_l_q[ni_q] <= flen_q + nl_q;
            stamp_q[ni_q] <= ctr_q;
          end else begin
            used_q[si_q]  <= 1'b1;
            ext_s_q[si_q] <= fpos_q[POS_BITS-1:0];
            ext_l_q[si_q] <= flen_q;
            stamp_q[si_q] <= ctr_q;
          end
        end
      end
      if (cmd_i.tally_clr) begin
        sum_q <= '0;
        cnt_q <= '0;
        idx_q <= '0;
        if (!fr_q && st_q != StOk) rpos_q <= '0;
      end
      if (cmd_i.scan_tally) begin
        if (used_q[idx_q]) begin
          sum_q <= sum_q + cur_l;
          cnt_q <= cnt_q + 1'b1;
        end
        idx_q <= sts_o.scan_last ? '0 : idx_q + 1'b1;
      end
      if (cmd_i.emit) begin
        done_o            <= 1'b1;
        status_o          <= st_q;
        result_position_o <= PosW'(rpos_q);
        free_total_o      <= LenW'(sum_q);
        fragment_count_o  <= 5'(cnt_q);
      end
    end
  end
endmodule
`default_nettype wire
